/* hw/rtl/sorted_software_timer_manager_defines.svh */
// Assertion macros shared by the timer manager RTL.
// Depends on a clock named clk_i and an active-low reset named rst_ni in the including module.
`ifndef SORTED_SOFTWARE_TIMER_MANAGER_DEFINES_SVH
`define SORTED_SOFTWARE_TIMER_MANAGER_DEFINES_SVH

// Checks that a property holds on every clock edge outside reset.
`define SSTM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define SSTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/sstm_pkg.sv */
// Package of the sorted timer manager: sizes, codes and word types.
// Used by every module of the block; depends on nothing.
package sstm_pkg;

  localparam int TIMERS = 32;
  localparam int QUEUES = 16;
  localparam int NSLOT = (TIMERS < 32) ? TIMERS : 32;
  localparam int SLOT_W = $clog2(NSLOT);
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NSLOT - 1);
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef logic [4:0] slot_field_t;

  typedef enum logic [2:0] {
    OP_ALLOC      = 3'd0,
    OP_FREE       = 3'd1,
    OP_BIND       = 3'd2,
    OP_ARM        = 3'd3,
    OP_CANCEL     = 3'd4,
    OP_CANCEL_ALL = 3'd5,
    OP_TICK       = 3'd6,
    OP_NONE       = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    K_ALLOC  = 3'd0,
    K_CANCEL = 3'd1,
    K_EXPIRY = 3'd2,
    K_SWITCH = 3'd3,
    K_ACK    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_ALLOC = 2'd1,
    ST_ARMED = 2'd2
  } st_e;

  typedef enum logic [0:0] {
    CFG_TASK_SLOT = 1'b0,
    CFG_TASK_EN   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]  action;
    slot_field_t slot;
    logic [31:0] timeout;
    logic [31:0] payload;
    logic [3:0]  queue_id;
    logic        cancellable;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    slot_field_t slot_out;
    logic        ok;
    logic [31:0] payload_out;
    logic [3:0]  queue_out;
    logic        last;
  } out_t;

  typedef struct packed {
    op_e         op;
    slot_field_t slot;
    logic        slot_ok;
    logic [31:0] timeout;
    logic [31:0] payload;
    logic [3:0]  queue_id;
    logic        queue_ok;
    logic        cancellable;
  } cmd_t;

  typedef struct packed {
    slot_field_t task_slot;
    logic        task_en;
  } cfg_t;

endpackage

/* hw/rtl/sstm_front.sv */
// Front end of the timer manager: accepts input words and classifies them into commands.
// Depends on sstm_pkg.
module sstm_front (
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sstm_pkg::in_t in_word_i,
  input  logic          full_i,
  output logic          push_o,
  output sstm_pkg::cmd_t cmd_o
);
  import sstm_pkg::*;

  op_e op;

  always_comb begin
    unique case (in_word_i.action)
      3'd0: op = OP_ALLOC;
      3'd1: op = OP_FREE;
      3'd2: op = OP_BIND;
      3'd3: op = OP_ARM;
      3'd4: op = OP_CANCEL;
      3'd5: op = OP_CANCEL_ALL;
      3'd6: op = OP_TICK;
      default: op = OP_NONE;
    endcase
  end

  assign in_stall_o = full_i;
  assign push_o = in_valid_i && !full_i;

  always_comb begin
    cmd_o.op = op;
    cmd_o.slot = in_word_i.slot;
    cmd_o.slot_ok = int'(in_word_i.slot) < NSLOT;
    cmd_o.timeout = in_word_i.timeout;
    cmd_o.payload = in_word_i.payload;
    cmd_o.queue_id = in_word_i.queue_id;
    cmd_o.queue_ok = int'(in_word_i.queue_id) < QUEUES;
    cmd_o.cancellable = in_word_i.cancellable;
  end

endmodule

/* hw/rtl/sstm_fifo.sv */
// Short command queue between the front end and the timer engine.
// Depends on sstm_pkg.
module sstm_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sstm_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output sstm_pkg::cmd_t data_o
);
  import sstm_pkg::*;

  cmd_t mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o = cnt_q == FIFO_CNT_W'(FIFO_DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* hw/rtl/sstm_back.sv */
// Timer engine: slot state, tick count, sequenced scans and the output register.
// Depends on sstm_pkg and the assertion macros header.
`include "sorted_software_timer_manager_defines.svh"

module sstm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_pop_o,
  input  sstm_pkg::cmd_t cmd_i,
  input  sstm_pkg::cfg_t cfg_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sstm_pkg::out_t out_word_o
);
  import sstm_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_CALL  = 6'b000100,
    S_TSCAN = 6'b001000,
    S_TPASS = 6'b010000,
    S_PUSH  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  cmd_t cmd_q, cmd_d;
  logic [31:0] count_q, count_d;
  logic [SLOT_W-1:0] idx_q, idx_d, best_q, best_d, best_rank_q, best_rank_d;
  logic [31:0] best_dl_q, best_dl_d;
  logic found_q, found_d, sw_q, sw_d, held_v_q, held_v_d;
  out_t held_q, held_d, res_q, res_d, out_q, out_d;
  logic out_valid_q, out_load;

  st_e status_q [NSLOT];
  logic [SLOT_W-1:0] rank_q [NSLOT];
  logic [31:0] dl_q [NSLOT];
  logic [31:0] pay_q [NSLOT];
  logic [3:0] que_q [NSLOT];
  logic canc_q [NSLOT];

  logic out_free;
  logic [SLOT_W-1:0] cs, rd_idx, q_addr, free_idx;
  logic [SLOT_W-1:0] rd_rank;
  logic [3:0] q_rd;
  logic [31:0] p_rd, dl_rd;
  logic free_any, is_task, cand, better;
  logic st_we, dis_en, arm_en, bind_en, canc_clr;
  logic [SLOT_W-1:0] st_idx, dis_idx, dis_rank;
  st_e st_val;
  out_t ack_res;

  assign out_free = !out_valid_q || !out_stall_i;
  assign cs = cmd_q.slot[SLOT_W-1:0];
  assign rd_idx = (state_q == S_CALL || state_q == S_TSCAN) ? idx_q : cs;
  assign rd_rank = rank_q[rd_idx];
  assign q_addr = (state_q == S_TPASS) ? best_q : idx_q;
  assign q_rd = que_q[q_addr];
  assign p_rd = pay_q[best_q];
  assign dl_rd = dl_q[idx_q];
  assign is_task = cfg_i.task_en && (slot_field_t'(best_q) == cfg_i.task_slot);
  assign cand = (status_q[idx_q] == ST_ARMED) && (dl_rd <= count_q);
  assign better = !found_q || (dl_rd < best_dl_q) ||
                  ((dl_rd == best_dl_q) && (rd_rank < best_rank_q));
  assign ack_res = '{kind: K_ACK, slot_out: '0, ok: 1'b0, payload_out: '0,
                     queue_out: '0, last: 1'b1};

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (status_q[i] == ST_FREE) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q;
    count_d = count_q;
    idx_d = idx_q;
    best_d = best_q;
    best_dl_d = best_dl_q;
    best_rank_d = best_rank_q;
    found_d = found_q;
    sw_d = sw_q;
    held_d = held_q;
    held_v_d = held_v_q;
    res_d = res_q;
    out_d = out_q;
    out_load = 1'b0;
    cmd_pop_o = 1'b0;
    st_we = 1'b0;
    st_idx = cs;
    st_val = ST_ALLOC;
    dis_en = 1'b0;
    dis_idx = cs;
    dis_rank = rd_rank;
    arm_en = 1'b0;
    bind_en = 1'b0;
    canc_clr = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d = cmd_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_d = ack_res;
        state_d = S_PUSH;
        unique case (cmd_q.op)
          OP_ALLOC: begin
            res_d.kind = K_ALLOC;
            if (free_any) begin
              st_we = 1'b1;
              st_idx = free_idx;
              canc_clr = 1'b1;
              res_d.slot_out = slot_field_t'(free_idx);
              res_d.ok = 1'b1;
            end
          end
          OP_FREE: begin
            if (cmd_q.slot_ok) begin
              dis_en = status_q[cs] == ST_ARMED;
              st_we = 1'b1;
              st_val = ST_FREE;
            end
          end
          OP_BIND: begin
            bind_en = cmd_q.slot_ok && cmd_q.queue_ok;
          end
          OP_ARM: begin
            if (cmd_q.slot_ok && status_q[cs] != ST_FREE) begin
              dis_en = status_q[cs] == ST_ARMED;
              arm_en = 1'b1;
              st_we = 1'b1;
              st_val = ST_ARMED;
            end
          end
          OP_CANCEL: begin
            res_d.kind = K_CANCEL;
            res_d.slot_out = cmd_q.slot;
            if (cmd_q.slot_ok && status_q[cs] == ST_ARMED) begin
              dis_en = 1'b1;
              st_we = 1'b1;
              res_d.ok = 1'b1;
            end
          end
          OP_CANCEL_ALL: begin
            if (cmd_q.queue_ok) begin
              idx_d = '0;
              state_d = S_CALL;
            end
          end
          OP_TICK: begin
            count_d = count_q + 32'd1;
            idx_d = '0;
            found_d = 1'b0;
            sw_d = 1'b0;
            held_v_d = 1'b0;
            state_d = S_TSCAN;
          end
          default: ;
        endcase
      end
      S_CALL: begin
        if (status_q[idx_q] != ST_FREE && canc_q[idx_q] && q_rd == cmd_q.queue_id) begin
          dis_en = status_q[idx_q] == ST_ARMED;
          dis_idx = idx_q;
          st_we = 1'b1;
          st_idx = idx_q;
          st_val = ST_FREE;
        end
        if (idx_q == LAST_IDX) begin
          res_d = ack_res;
          state_d = S_PUSH;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_TSCAN: begin
        if (cand && better) begin
          best_d = idx_q;
          best_dl_d = dl_rd;
          best_rank_d = rd_rank;
          found_d = 1'b1;
        end
        if (idx_q == LAST_IDX) begin
          state_d = S_TPASS;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_TPASS: begin
        if (found_q) begin
          if (is_task || !held_v_q || out_free) begin
            dis_en = 1'b1;
            dis_idx = best_q;
            dis_rank = best_rank_q;
            st_we = 1'b1;
            st_idx = best_q;
            idx_d = '0;
            found_d = 1'b0;
            state_d = S_TSCAN;
            if (is_task) begin
              sw_d = 1'b1;
            end else begin
              if (held_v_q) begin
                out_load = 1'b1;
                out_d = held_q;
              end
              held_v_d = 1'b1;
              held_d = '{kind: K_EXPIRY, slot_out: slot_field_t'(best_q), ok: 1'b0,
                         payload_out: p_rd, queue_out: q_rd, last: 1'b0};
            end
          end
        end else if (sw_q) begin
          if (held_v_q) begin
            if (out_free) begin
              out_load = 1'b1;
              out_d = held_q;
              held_v_d = 1'b0;
            end
          end else begin
            res_d = '{kind: K_SWITCH, slot_out: cfg_i.task_slot, ok: 1'b0,
                      payload_out: '0, queue_out: '0, last: 1'b1};
            state_d = S_PUSH;
          end
        end else if (held_v_q) begin
          res_d = held_q;
          res_d.last = 1'b1;
          held_v_d = 1'b0;
          state_d = S_PUSH;
        end else begin
          res_d = ack_res;
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d = res_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      found_q <= 1'b0;
      sw_q <= 1'b0;
      held_v_q <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q <= '0;
      for (int i = 0; i < NSLOT; i++) begin
        status_q[i] <= ST_FREE;
        canc_q[i] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      found_q <= found_d;
      sw_q <= sw_d;
      held_v_q <= held_v_d;
      idx_q <= idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (st_we) begin
        status_q[st_idx] <= st_val;
      end
      if (canc_clr) begin
        canc_q[st_idx] <= 1'b0;
      end
      if (bind_en) begin
        canc_q[cs] <= cmd_q.cancellable;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    best_q <= best_d;
    best_dl_q <= best_dl_d;
    best_rank_q <= best_rank_d;
    held_q <= held_d;
    res_q <= res_d;
    if (out_load) begin
      out_q <= out_d;
    end
    if (bind_en) begin
      pay_q[cs] <= cmd_q.payload;
      que_q[cs] <= cmd_q.queue_id;
    end
    if (arm_en) begin
      dl_q[cs] <= cmd_q.timeout + count_q;
    end
    for (int i = 0; i < NSLOT; i++) begin
      if (arm_en && SLOT_W'(i) == cs) begin
        rank_q[i] <= '0;
      end else if (status_q[i] == ST_ARMED) begin
        if (dis_en && SLOT_W'(i) != dis_idx && rank_q[i] > dis_rank) begin
          if (!arm_en) begin
            rank_q[i] <= rank_q[i] - 1'b1;
          end
        end else if (arm_en) begin
          rank_q[i] <= rank_q[i] + 1'b1;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o = out_q;

  `SSTM_ASSERT(a_no_overwrite, !(out_valid_q && out_stall_i && out_load),
               "output word overwritten while stalled")
  `SSTM_ASSERT_NEXT(a_expired_disarmed, (state_q == S_TPASS) && dis_en,
                    status_q[$past(best_q)] != ST_ARMED, "expired slot still armed")
  `SSTM_ASSERT(a_held_in_tick, !held_v_q || state_q == S_TSCAN || state_q == S_TPASS,
               "held expiry outside a tick")

endmodule

/* hw/rtl/sorted_software_timer_manager.sv */
// Sorted timer manager: an input channel of action words, a result channel and a
// two-register write port (task slot, task slot enable).
// An input word is accepted when in_valid_i is high and in_stall_o is low; a result
// word leaves when out_valid_o is high and out_stall_i is low. Every input word gives
// one or more results, the final one marked by last.
// The front end decodes each word into a two-entry command queue; the engine takes one
// command at a time. A simple command goes through the execute and push states to the
// output register. Cancel-all scans every slot, one per cycle. A tick runs one scan of
// all slots per expired timer plus one final scan. The slot scan sets the rate.
// Reset frees all slots, clears the tick count and the registers, and empties both sides.
// While the receiver stalls, the result register holds its word and the engine waits before
// loading the next; the front keeps accepting words until the command queue is full.
module sorted_software_timer_manager (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sstm_pkg::in_t     in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sstm_pkg::out_t    out_word_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [4:0]        cfg_data_i
);
  import sstm_pkg::*;

  cfg_t cfg_q;
  cmd_t push_cmd, pop_cmd;
  logic push, full, pop, cmd_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TASK_SLOT: cfg_q.task_slot <= cfg_data_i;
        CFG_TASK_EN:   cfg_q.task_en <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  sstm_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  sstm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (cmd_valid),
    .data_o  (pop_cmd)
  );

  sstm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (pop),
    .cmd_i       (pop_cmd),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
